@@ design/mafs_pkg.sv @@
// shared types, constants and header lookup tables for the mpeg audio frame sync block
package mafs_pkg;

   localparam int QuoBits = 12;
   localparam int NumBits = 26;
   localparam int DenBits = 17;

   localparam logic [10:0] SYNC_WORD = 11'h7ff;
   localparam logic [1:0] VER_RESERVED = 2'b01;
   localparam logic [1:0] LAYER_RESERVED = 2'b00;
   localparam logic [1:0] RATE_RESERVED = 2'b11;
   localparam logic [1:0] MODE_MONO = 2'b11;
   localparam logic [1:0] LAYER_ONE = 2'd1;
   localparam logic [1:0] LAYER_THREE = 2'd3;

   localparam logic [17:0] MUL_LAYER_ONE = 18'd12000;
   localparam logic [17:0] MUL_LAYER_OTHER = 18'd144000;

   localparam logic [8:0] KBPS [2][3][16] = '{
      '{'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
          9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
        '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
          9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}},
      '{'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
        '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
          9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
        '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
          9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}}};

   localparam logic [16:0] RATE_HZ [9] = '{
      17'd44100, 17'd48000, 17'd32000,
      17'd22050, 17'd24000, 17'd16000,
      17'd11025, 17'd12000, 17'd8000};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_START,
      ST_DIVIDE,
      ST_BURST
   } mafs_state_type;

   typedef struct packed {
      logic       accept;
      logic       check;
      logic       div_start;
      logic       emit;
      logic [1:0] emit_idx;
      logic       finish;
   } mafs_cmd_type;

   typedef struct packed {
      logic hunt_full;
      logic hdr_ok;
      logic div_done;
      logic out_free;
   } mafs_sts_type;

   function automatic logic [8:0] kbps_lookup(input logic lsf, input logic [1:0] lidx,
                                              input logic [3:0] bidx);
      if (lidx == 2'd3) begin
         return 9'd0;
      end
      return KBPS[lsf][lidx][bidx];
   endfunction

   function automatic logic [16:0] rate_lookup(input logic [3:0] ridx);
      if (ridx > 4'd8) begin
         return 17'd0;
      end
      return RATE_HZ[ridx];
   endfunction

endpackage

@@ design/mafs_div.sv @@
// restoring divider, one quotient bit per cycle
module mafs_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mafs_pkg::NumBits-1:0] num,
   input  logic [mafs_pkg::DenBits-1:0] den,
   output logic                         done,
   output logic [mafs_pkg::QuoBits-1:0] quo
);
   import mafs_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [DenBits-1:0] rem_ff, rem_in;
   logic [DenBits-1:0] den_ff, den_in;
   logic [QuoBits-1:0] low_ff, low_in;
   logic [QuoBits-1:0] quo_ff, quo_in;
   logic [DenBits:0]   trial;
   logic [DenBits:0]   diff;
   logic               ge;

   // the quotient of every legal header fits in QuoBits, so the top part is below den
   assign trial = {rem_ff, low_ff[QuoBits-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd0;
         rem_in  = DenBits'(num[NumBits-1:QuoBits]);
         low_in  = num[QuoBits-1:0];
         den_in  = den;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DenBits-1:0] : trial[DenBits-1:0];
         low_in = {low_ff[QuoBits-2:0], 1'b0};
         quo_in = {quo_ff[QuoBits-2:0], ge};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(QuoBits - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

@@ design/mafs_dp.sv @@
// datapath: hunt window, header decode, frame size, byte counter and output register
module mafs_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  mafs_pkg::mafs_cmd_type cmd,
   output mafs_pkg::mafs_sts_type sts,
   input  logic [7:0]            req_in_byte,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_frame_start,
   output logic                  rsp_frame_end,
   output logic [11:0]           rsp_frame_size,
   output logic [1:0]            rsp_layer,
   output logic [3:0]            rsp_rate_index,
   output logic [1:0]            rsp_channels,
   output logic                  rsp_last
);
   import mafs_pkg::*;

   logic [23:0] window_ff, window_in;
   logic [1:0]  fill_ff, fill_in;
   logic [11:0] left_ff, left_in;
   logic [31:0] hdr_ff, hdr_in;
   logic        passing;
   logic [31:0] cand;

   // decode of the held candidate
   logic [1:0]  d_lay;
   logic        d_lsf;
   logic [3:0]  d_ridx;
   logic [8:0]  d_br;
   logic [16:0] d_den;
   logic [17:0] d_mul;
   logic [26:0] d_prod;
   logic        d_ok;

   logic [NumBits-1:0] num_ff, num_in;
   logic [DenBits-1:0] den_ff, den_in;
   logic [1:0]         lay_ff, lay_in;
   logic [3:0]         ridx_ff, ridx_in;
   logic [1:0]         ch_ff, ch_in;
   logic               pad_ff, pad_in;
   logic [11:0]        len_ff, len_in;
   logic [11:0]        qsum;

   logic               div_done;
   logic [QuoBits-1:0] quo;

   logic        ov_ff, ov_in;
   logic [7:0]  ob_ff, ob_in;
   logic        ofs_ff, ofs_in;
   logic        ofe_ff, ofe_in;
   logic [11:0] ofl_ff, ofl_in;
   logic [1:0]  oly_ff, oly_in;
   logic [3:0]  ori_ff, ori_in;
   logic [1:0]  och_ff, och_in;
   logic        olast_ff, olast_in;

   assign passing = left_ff != 12'd0;
   assign cand    = {window_ff, req_in_byte};

   always_comb begin
      d_lay = 2'(3'd4 - {1'b0, hdr_ff[18:17]});
      if (hdr_ff[20]) begin
         d_lsf  = ~hdr_ff[19];
         d_ridx = hdr_ff[19] ? {2'b00, hdr_ff[11:10]} : 4'({2'b00, hdr_ff[11:10]} + 4'd3);
      end else begin
         d_lsf  = 1'b1;
         d_ridx = 4'({2'b00, hdr_ff[11:10]} + 4'd6);
      end
      d_br  = kbps_lookup(d_lsf, 2'(d_lay - 2'd1), hdr_ff[15:12]);
      d_den = rate_lookup(d_ridx);
      if (d_lay == LAYER_THREE && d_lsf) begin
         d_den = {d_den[15:0], 1'b0};
      end
      d_mul  = (d_lay == LAYER_ONE) ? MUL_LAYER_ONE : MUL_LAYER_OTHER;
      d_prod = 27'(d_br) * 27'(d_mul);
      d_ok   = (hdr_ff[31:21] == SYNC_WORD) && (hdr_ff[11:10] != RATE_RESERVED)
               && (hdr_ff[20:19] != VER_RESERVED) && (hdr_ff[18:17] != LAYER_RESERVED)
               && (d_br != 9'd0);
   end

   mafs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (quo)
   );

   assign qsum = quo + {11'd0, pad_ff};

   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      left_in   = left_ff;
      hdr_in    = hdr_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      lay_in    = lay_ff;
      ridx_in   = ridx_ff;
      ch_in     = ch_ff;
      pad_in    = pad_ff;
      len_in    = len_ff;
      if (cmd.accept && !passing) begin
         if (fill_ff != 2'd3) begin
            window_in = {window_ff[15:0], req_in_byte};
            fill_in   = fill_ff + 2'd1;
         end else begin
            window_in = cand[23:0];
            hdr_in    = cand;
         end
      end
      if (cmd.accept && passing) begin
         left_in = left_ff - 12'd1;
      end
      if (cmd.check) begin
         num_in  = d_prod[NumBits-1:0];
         den_in  = d_den;
         lay_in  = d_lay;
         ridx_in = d_ridx;
         ch_in   = (hdr_ff[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
         pad_in  = hdr_ff[9];
      end
      if (div_done) begin
         len_in = (lay_ff == LAYER_ONE) ? {qsum[9:0], 2'b00} : qsum;
      end
      if (cmd.finish) begin
         left_in   = len_ff - 12'd4;
         window_in = '0;
         fill_in   = 2'd0;
      end
   end

   // output register
   always_comb begin
      ov_in    = ov_ff & ~rsp_ready;
      ob_in    = ob_ff;
      ofs_in   = ofs_ff;
      ofe_in   = ofe_ff;
      ofl_in   = ofl_ff;
      oly_in   = oly_ff;
      ori_in   = ori_ff;
      och_in   = och_ff;
      olast_in = olast_ff;
      if (cmd.accept && passing) begin
         ov_in    = 1'b1;
         ob_in    = req_in_byte;
         ofs_in   = 1'b0;
         ofe_in   = left_ff == 12'd1;
         ofl_in   = '0;
         oly_in   = '0;
         ori_in   = '0;
         och_in   = '0;
         olast_in = 1'b1;
      end else if (cmd.emit) begin
         ov_in    = 1'b1;
         ob_in    = hdr_ff[31 - 8 * cmd.emit_idx -: 8];
         ofs_in   = cmd.emit_idx == 2'd0;
         ofe_in   = (cmd.emit_idx == 2'd3) && (len_ff == 12'd4);
         olast_in = cmd.emit_idx == 2'd3;
         if (cmd.emit_idx == 2'd0) begin
            ofl_in = len_ff;
            oly_in = lay_ff;
            ori_in = ridx_ff;
            och_in = ch_ff;
         end else begin
            ofl_in = '0;
            oly_in = '0;
            ori_in = '0;
            och_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         fill_ff   <= 2'd0;
         left_ff   <= 12'd0;
         ov_ff     <= 1'b0;
      end else begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
         left_ff   <= left_in;
         ov_ff     <= ov_in;
      end
      hdr_ff   <= hdr_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      lay_ff   <= lay_in;
      ridx_ff  <= ridx_in;
      ch_ff    <= ch_in;
      pad_ff   <= pad_in;
      len_ff   <= len_in;
      ob_ff    <= ob_in;
      ofs_ff   <= ofs_in;
      ofe_ff   <= ofe_in;
      ofl_ff   <= ofl_in;
      oly_ff   <= oly_in;
      ori_ff   <= ori_in;
      och_ff   <= och_in;
      olast_ff <= olast_in;
   end

   assign sts.hunt_full = !passing && (fill_ff == 2'd3);
   assign sts.hdr_ok    = d_ok;
   assign sts.div_done  = div_done;
   assign sts.out_free  = !ov_ff || rsp_ready;

   assign rsp_valid       = ov_ff;
   assign rsp_out_byte    = ob_ff;
   assign rsp_frame_start = ofs_ff;
   assign rsp_frame_end   = ofe_ff;
   assign rsp_frame_size  = ofl_ff;
   assign rsp_layer       = oly_ff;
   assign rsp_rate_index  = ori_ff;
   assign rsp_channels    = och_ff;
   assign rsp_last        = olast_ff;

endmodule

@@ design/mafs_ctrl.sv @@
// controller: sequences accept, header check, division and the header burst
module mafs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mafs_pkg::mafs_sts_type sts,
   output mafs_pkg::mafs_cmd_type cmd
);
   import mafs_pkg::*;

   mafs_state_type state_ff, state_in;
   logic [1:0]     idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.out_free && sts.hunt_full) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = sts.hdr_ok ? ST_START : ST_IDLE;
         end
         ST_START: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (sts.div_done) begin
               state_in = ST_BURST;
            end
         end
         ST_BURST: begin
            if (sts.out_free && idx_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.accept    = 1'b0;
      cmd.check     = 1'b0;
      cmd.div_start = 1'b0;
      cmd.emit      = 1'b0;
      cmd.emit_idx  = idx_ff;
      cmd.finish    = 1'b0;
      idx_in        = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = sts.out_free;
            cmd.accept = req_valid && sts.out_free;
            idx_in     = 2'd0;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
         end
         ST_START: begin
            cmd.div_start = 1'b1;
         end
         ST_DIVIDE: begin
            idx_in = 2'd0;
         end
         ST_BURST: begin
            if (sts.out_free) begin
               cmd.emit   = 1'b1;
               cmd.finish = idx_ff == 2'd3;
               idx_in     = idx_ff + 2'd1;
            end
         end
         default: begin
            idx_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

@@ design/mpeg_audio_frame_sync.sv @@
// top level of the mpeg audio frame sync block
// Takes a compressed MPEG audio stream one byte per transaction, slides a
// four-byte window over it until a legal MPEG-1/2/2.5 layer I-III header
// shows up, then sends the four header bytes (the first one tagged with
// frame_start, frame size, layer, rate index and channel count) followed by
// every remaining byte of the frame, frame_end on the final one. Inside a frame
// each byte leaves as one result transaction. While hunting, a byte that only
// fills the window is just accepted, and a byte that completes a rejected
// candidate goes through accept and header check. A byte that completes a
// legal header goes through accept, header check with the bitrate multiply,
// divider start, 12 steps of the bit-serial frame size divider, taking the
// quotient, then the four-result header burst through the single output
// register. A full output register that the result side does not take holds
// off input and burst alike.
module mpeg_audio_frame_sync (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_start,
   output logic        rsp_frame_end,
   output logic [11:0] rsp_frame_size,
   output logic [1:0]  rsp_layer,
   output logic [3:0]  rsp_rate_index,
   output logic [1:0]  rsp_channels,
   output logic        rsp_last
);
   import mafs_pkg::*;

   mafs_cmd_type cmd;
   mafs_sts_type sts;

   mafs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mafs_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_in_byte     (req_in_byte),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_frame_start (rsp_frame_start),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_frame_size  (rsp_frame_size),
      .rsp_layer       (rsp_layer),
      .rsp_rate_index  (rsp_rate_index),
      .rsp_channels    (rsp_channels),
      .rsp_last        (rsp_last)
   );

endmodule

@@ bench/mpeg_audio_frame_sync_tb.sv @@
// self-checking testbench for the mpeg audio frame sync block
module mpeg_audio_frame_sync_tb;
   import mafs_pkg::VER_RESERVED;
   import mafs_pkg::LAYER_RESERVED;
   import mafs_pkg::RATE_RESERVED;
   import mafs_pkg::MODE_MONO;

   localparam logic [1:0] VER_MPEG1 = 2'b11;
   localparam logic [1:0] VER_MPEG2 = 2'b10;
   localparam logic [1:0] VER_MPEG25 = 2'b00;
   localparam logic [1:0] LBITS_II = 2'b10;
   localparam logic [1:0] LBITS_III = 2'b01;
   localparam logic [3:0] BR_FREE = 4'd0;
   localparam logic [3:0] BR_BAD = 4'd15;
   localparam logic [10:0] SYNC_BITS = 11'h7ff;
   localparam int MUL_L1 = 12000;
   localparam int MUL_L23 = 144000;

   localparam int NUM_PHASES = 4;
   localparam int MODE_NONE = 0;
   localparam int MODE_SEND_IDLE = 1;
   localparam int MODE_RECV_STALL = 2;
   localparam int MODE_BOTH = 3;
   localparam int RANDOM_PER_PHASE = 60;
   localparam int SMALL_FRAME_CAP = 140;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;

   localparam int KBPS_TAB [2][3][16] = '{
      '{'{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
        '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
        '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}},
      '{'{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
        '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
        '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}}};

   localparam int RATE_TAB [9] = '{44100, 48000, 32000, 22050, 24000, 16000,
                                   11025, 12000, 8000};

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        frame_start;
      logic        frame_end;
      logic [11:0] frame_size;
      logic [1:0]  layer;
      logic [3:0]  rate_index;
      logic [1:0]  channels;
      logic        last;
   } frame_rsp_type;

   // quiet = 1: no result transaction may come for this byte
   typedef struct packed {
      logic [7:0] value;
      logic       quiet;
   } stim_row_type;

   localparam int NUM_DIRECTED = 20;
   localparam stim_row_type DIRECTED [NUM_DIRECTED] = '{
      // window fill after reset, then reserved version
      '{8'hff, 1'b1}, '{8'heb, 1'b1}, '{8'h90, 1'b1}, '{8'h00, 1'b1},
      // reserved layer
      '{8'hff, 1'b1}, '{8'hf9, 1'b1}, '{8'h90, 1'b1}, '{8'h00, 1'b1},
      // reserved sample rate
      '{8'hff, 1'b1}, '{8'hfb, 1'b1}, '{8'h9c, 1'b1}, '{8'h00, 1'b1},
      // free format bitrate
      '{8'hff, 1'b1}, '{8'hfb, 1'b1}, '{8'h00, 1'b1}, '{8'h00, 1'b1},
      // bitrate index 15
      '{8'hff, 1'b1}, '{8'hfb, 1'b1}, '{8'hf0, 1'b1}, '{8'h00, 1'b1}};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_frame_start;
   logic        rsp_frame_end;
   logic [11:0] rsp_frame_size;
   logic [1:0]  rsp_layer;
   logic [3:0]  rsp_rate_index;
   logic [1:0]  rsp_channels;
   logic        rsp_last;

   logic [7:0]  stim_bytes [$];
   int          phase_start [NUM_PHASES];
   int          send_idx = 0;
   int          in_count = 0;
   int          fail_count = 0;
   int          quiet_cycles = 0;
   logic        timed_out = 1'b0;

   frame_rsp_type frame_bytes_due [$];
   logic [23:0] win_bytes = '0;
   int          win_count = 0;
   logic [11:0] bytes_in_frame = '0;

   mpeg_audio_frame_sync dut (.*);

   always #6 clock = ~clock;

   // frame size of a candidate header, 0 when it is not a legal header
   function automatic logic [11:0] header_size(input logic [31:0] hdr,
                                               output logic [1:0] ly,
                                               output logic [3:0] ri,
                                               output logic [1:0] ch);
      int lyr, lsf, sidx, kbps, div, size;
      ly = '0;
      ri = '0;
      ch = '0;
      if (hdr[31:21] != SYNC_BITS || hdr[11:10] == RATE_RESERVED ||
          hdr[20:19] == VER_RESERVED || hdr[18:17] == LAYER_RESERVED) begin
         return 12'd0;
      end
      lyr = 4 - int'(hdr[18:17]);
      lsf = (hdr[20:19] == VER_MPEG1) ? 0 : 1;
      sidx = int'(hdr[11:10]) +
             ((hdr[20:19] == VER_MPEG1) ? 0 : (hdr[20:19] == VER_MPEG2) ? 3 : 6);
      kbps = KBPS_TAB[lsf][lyr - 1][hdr[15:12]];
      if (kbps == 0) begin
         return 12'd0;
      end
      // layer iii at low sample frequency halves the frame
      div = (lyr == 3) ? (RATE_TAB[sidx] << lsf) : RATE_TAB[sidx];
      size = kbps * ((lyr == 1) ? MUL_L1 : MUL_L23) / div + int'(hdr[9]);
      if (lyr == 1) begin
         size = size * 4;
      end
      ly = lyr[1:0];
      ri = sidx[3:0];
      ch = (hdr[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
      return size[11:0];
   endfunction

   // advances the frame tracker by one byte, queueing what it should emit
   function automatic void predict_frame_bytes(input logic [7:0] b, input logic keep);
      frame_rsp_type r;
      logic [31:0] cand;
      logic [11:0] size;
      logic [1:0]  ly, ch;
      logic [3:0]  ri;
      if (bytes_in_frame != 0) begin
         r = '0;
         r.out_byte = b;
         r.frame_end = (bytes_in_frame == 12'd1);
         r.last = 1'b1;
         bytes_in_frame = bytes_in_frame - 12'd1;
         if (keep) frame_bytes_due.push_back(r);
         return;
      end
      if (win_count < 3) begin
         win_bytes = {win_bytes[15:0], b};
         win_count++;
         return;
      end
      cand = {win_bytes, b};
      size = header_size(cand, ly, ri, ch);
      if (size == 0) begin
         win_bytes = cand[23:0];
         return;
      end
      for (int k = 0; k < 4; k++) begin
         r = '0;
         r.out_byte = cand[8 * (3 - k) +: 8];
         r.frame_end = (k == 3 && size == 12'd4);
         r.last = (k == 3);
         if (k == 0) begin
            r.frame_start = 1'b1;
            r.frame_size = size;
            r.layer = ly;
            r.rate_index = ri;
            r.channels = ch;
         end
         if (keep) frame_bytes_due.push_back(r);
      end
      bytes_in_frame = (size >= 12'd4) ? size - 12'd4 : 12'd0;
      win_bytes = '0;
      win_count = 0;
   endfunction

   function automatic logic [31:0] pack_header(input logic [1:0] ver, input logic [1:0] lbits,
                                               input logic [3:0] bidx, input logic [1:0] sbits,
                                               input logic pad);
      logic [8:0] tail;
      logic       prot;
      tail = 9'($urandom_range(0, 511));
      prot = 1'($urandom_range(0, 1));
      return {SYNC_BITS, ver, lbits, prot, bidx, sbits, pad, tail};
   endfunction

   function automatic logic [31:0] random_header(input int cap);
      logic [31:0] hdr;
      logic [1:0]  ver, ly, ch;
      logic [3:0]  ri;
      logic [11:0] size;
      do begin
         case ($urandom_range(0, 2))
            0: ver = VER_MPEG1;
            1: ver = VER_MPEG2;
            default: ver = VER_MPEG25;
         endcase
         hdr = pack_header(ver, 2'($urandom_range(1, 3)), 4'($urandom_range(1, 14)),
                           2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
         size = header_size(hdr, ly, ri, ch);
      end while (size == 0 || int'(size) > cap);
      return hdr;
   endfunction

   function automatic void push_frame(input logic [31:0] hdr);
      logic [1:0]  ly, ch;
      logic [3:0]  ri;
      logic [11:0] size;
      size = header_size(hdr, ly, ri, ch);
      for (int k = 0; k < 4; k++) stim_bytes.push_back(hdr[8 * (3 - k) +: 8]);
      for (int k = 4; k < int'(size); k++) stim_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic int idle_mode(input int idx);
      int m;
      m = MODE_NONE;
      for (int p = 1; p < NUM_PHASES; p++) begin
         if (idx >= phase_start[p]) m = p;
      end
      return m;
   endfunction

   function automatic logic sender_go(input int m);
      if (m == MODE_SEND_IDLE) return $urandom_range(0, 99) >= 85;
      if (m == MODE_BOTH) return $urandom_range(0, 99) >= 11;
      return 1'b1;
   endfunction

   function automatic logic receiver_go(input int m);
      if (m == MODE_RECV_STALL) return $urandom_range(0, 99) >= 85;
      if (m == MODE_BOTH) return $urandom_range(0, 99) >= 11;
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // stimulus and ready, both driven right after the edge
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_ready) begin
            if (send_idx < stim_bytes.size() && sender_go(idle_mode(send_idx))) begin
               req_valid <= 1'b1;
               req_in_byte <= stim_bytes[send_idx];
               send_idx <= send_idx + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= receiver_go(idle_mode(send_idx));
      end
   end

   // prediction on input transactions, checking on result transactions
   always @(posedge clock) begin
      frame_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_frame_bytes(req_in_byte,
                                !(in_count < NUM_DIRECTED && DIRECTED[in_count].quiet));
            in_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (frame_bytes_due.size() == 0) begin
               $error("unexpected result transaction: out_byte %0h", rsp_out_byte);
               fail_count++;
            end else begin
               want = frame_bytes_due.pop_front();
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("frame_start", want.frame_start, rsp_frame_start);
               check_field("frame_end", want.frame_end, rsp_frame_end);
               check_field("frame_size", want.frame_size, rsp_frame_size);
               check_field("layer", want.layer, rsp_layer);
               check_field("rate_index", want.rate_index, rsp_rate_index);
               check_field("channels", want.channels, rsp_channels);
               check_field("last", want.last, rsp_last);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            timed_out <= 1'b1;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      int          base;
      int          pick;
      logic [31:0] hdr;
      for (int i = 0; i < NUM_DIRECTED; i++) stim_bytes.push_back(DIRECTED[i].value);
      for (int p = 0; p < NUM_PHASES; p++) begin
         phase_start[p] = (p == 0) ? 0 : stim_bytes.size();
         if (p == 0) begin
            // shortest legal frame
            push_frame(pack_header(VER_MPEG2, LBITS_III, 4'd1, 2'd1, 1'b0));
         end
         base = stim_bytes.size();
         while (stim_bytes.size() - base < RANDOM_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               push_frame(random_header(SMALL_FRAME_CAP));
            end else if (pick < 85) begin
               repeat ($urandom_range(1, 6)) begin
                  stim_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'hff :
                                       8'($urandom_range(0, 255)));
               end
            end else begin
               // legal header with one field broken
               hdr = random_header(SMALL_FRAME_CAP);
               case ($urandom_range(0, 5))
                  0: hdr[20:19] = VER_RESERVED;
                  1: hdr[18:17] = LAYER_RESERVED;
                  2: hdr[11:10] = RATE_RESERVED;
                  3: hdr[15:12] = BR_FREE;
                  4: hdr[15:12] = BR_BAD;
                  default: hdr[21 + $urandom_range(0, 10)] = 1'b0;
               endcase
               for (int k = 0; k < 4; k++) stim_bytes.push_back(hdr[8 * (3 - k) +: 8]);
            end
         end
      end
      // longest legal frame last: only its header burst is sent and checked
      hdr = pack_header(VER_MPEG25, LBITS_II, 4'd14, 2'd2, 1'b1);
      for (int k = 0; k < 4; k++) stim_bytes.push_back(hdr[8 * (3 - k) +: 8]);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (!timed_out && !(send_idx == stim_bytes.size() && !req_valid &&
                             frame_bytes_due.size() == 0)) begin
         @(posedge clock);
      end
      if (!timed_out) begin
         repeat (DRAIN_CYCLES) @(posedge clock);
      end

      if (timed_out) begin
         $display("*** FAILED ***");
      end else if (fail_count == 0 && frame_bytes_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
